FILE: rtl/core/qls_pkg.sv
// ----------------------------------------------------------------------------
// qls_pkg
// Shared constants and types for the quorum leader select core.
// ----------------------------------------------------------------------------
`default_nettype none

package qls_pkg;

  localparam int MAX_MEMBERS  = 16;
  localparam int SLOT_W       = 4;
  localparam int UID_W        = 64;
  localparam int PROP_W       = 32;
  localparam int FACTOR_W     = 9;
  localparam int FRAC_W       = 8;
  localparam int CIDX_W       = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CMP_W        = (CIDX_W > SLOT_W) ? CIDX_W : SLOT_W;
  localparam int CNT_W        = $clog2(MAX_MEMBERS + 1);
  localparam int MAJ_W        = CNT_W + FACTOR_W;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(128);

  // member write broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic              present;
    logic              alive;
    logic              id_known;
    logic [UID_W-1:0]  uid_high;
    logic [UID_W-1:0]  uid_low;
    logic [PROP_W-1:0] proposal;
  } member_wr_t;

  // scan record passed from cell to cell
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [PROP_W-1:0] proposal;
    logic [UID_W-1:0]  uid_high;
    logic [UID_W-1:0]  uid_low;
    logic [CNT_W-1:0]  live_cnt;
    logic [CNT_W-1:0]  present_cnt;
  } scan_t;

endpackage

`default_nettype wire

FILE: rtl/core/qls_item_if.sv
// ----------------------------------------------------------------------------
// qls_item_if
// Member write channel: valid, ready and one member record.
// ----------------------------------------------------------------------------
`default_nettype none

interface qls_item_if;
  logic                          valid;
  logic                          ready;
  logic [qls_pkg::SLOT_W-1:0]    slot;
  logic                          present;
  logic                          alive;
  logic                          id_known;
  logic [qls_pkg::UID_W-1:0]     uid_high;
  logic [qls_pkg::UID_W-1:0]     uid_low;
  logic [qls_pkg::PROP_W-1:0]    proposal;

  modport source (
    output valid, slot, present, alive, id_known, uid_high, uid_low, proposal,
    input  ready
  );
  modport sink (
    input  valid, slot, present, alive, id_known, uid_high, uid_low, proposal,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/qls_result_if.sv
// ----------------------------------------------------------------------------
// qls_result_if
// Result channel: majority flag and elected leader.
// ----------------------------------------------------------------------------
`default_nettype none

interface qls_result_if;
  logic                          valid;
  logic                          ready;
  logic                          majority;
  logic                          leader_valid;
  logic [qls_pkg::SLOT_W-1:0]    leader_slot;

  modport source (
    output valid, majority, leader_valid, leader_slot,
    input  ready
  );
  modport sink (
    input  valid, majority, leader_valid, leader_slot,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/qls_cfg_if.sv
// ----------------------------------------------------------------------------
// qls_cfg_if
// Configuration write channel for the majority factor.
// ----------------------------------------------------------------------------
`default_nettype none

interface qls_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [qls_pkg::FACTOR_W-1:0]  quorum_frac;

  modport source (
    output valid, quorum_frac,
    input  ready
  );
  modport sink (
    input  valid, quorum_frac,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/qls_cell.sv
// ----------------------------------------------------------------------------
// qls_cell
// One member slot: holds the member record and folds it into the scan
// record that passes through on its way down the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module qls_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [qls_pkg::CIDX_W-1:0] idx,
  input  wire qls_pkg::member_wr_t        wr,
  input  wire logic                       adv,
  input  wire logic                       up_valid,
  input  wire qls_pkg::scan_t             up,
  output logic                            dn_valid,
  output qls_pkg::scan_t                  dn
);
  import qls_pkg::*;

  logic              present;
  logic              alive;
  logic              id_known;
  logic [UID_W-1:0]  uid_high;
  logic [UID_W-1:0]  uid_low;
  logic [PROP_W-1:0] proposal;

  logic              hit;
  logic              live;
  logic              cand;
  logic              better;
  scan_t             dn_next;

  assign hit  = wr.en && (CMP_W'(wr.slot) == CMP_W'(idx));
  assign live = present && alive;
  assign cand = live && id_known;

  always_ff @(posedge clk) begin
    if (rst) begin
      present  <= 1'b0;
      alive    <= 1'b0;
      id_known <= 1'b0;
    end else if (hit) begin
      present  <= wr.present;
      alive    <= wr.alive;
      id_known <= wr.id_known;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      uid_high <= wr.uid_high;
      uid_low  <= wr.uid_low;
      proposal <= wr.proposal;
    end
  end

  // ties on proposal go to the lower id, equal ids keep the earlier slot
  always_comb begin
    better = !up.found
          || (proposal > up.proposal)
          || ((proposal == up.proposal)
              && ({uid_high, uid_low} < {up.uid_high, up.uid_low}));
    dn_next             = up;
    dn_next.live_cnt    = up.live_cnt + CNT_W'(live);
    dn_next.present_cnt = up.present_cnt + CNT_W'(present);
    if (cand && better) begin
      dn_next.found    = 1'b1;
      dn_next.slot     = SLOT_W'(idx);
      dn_next.proposal = proposal;
      dn_next.uid_high = uid_high;
      dn_next.uid_low  = uid_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn <= dn_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/quorum_leader_select_core.sv
// ----------------------------------------------------------------------------
// quorum_leader_select_core
// Member table with majority check and leader election, scanned by a
// chain of member cells.
// ----------------------------------------------------------------------------
//  channel  dir  transfer moves
//  item     in   slot, present, alive, id_known, uid_high, uid_low, proposal
//  result   out  majority, leader_valid, leader_slot
//  cfg      in   quorum_frac
//
//  an item writes its slot at the transfer, then a scan record walks the
//  MAX_MEMBERS cells one per cycle while no stalled result holds it; the
//  result is registered from the record at the chain end, and the next item
//  is taken once the scan leaves the chain.
//  rst clears all member flags and sets the majority factor to 128.
//  a stalled result holds the finished scan at the chain end.
// ----------------------------------------------------------------------------
`default_nettype none

module quorum_leader_select_core (
  input  wire logic clk,
  input  wire logic rst,
  qls_item_if.sink     item,
  qls_cfg_if.sink      cfg,
  qls_result_if.source result
);
  import qls_pkg::*;

  logic [FACTOR_W-1:0]     factor;
  logic                    start;
  logic                    adv;
  logic                    busy;
  logic                    item_xfer;
  logic [MAX_MEMBERS:0]    chain_valid;
  scan_t                   chain [MAX_MEMBERS+1];
  member_wr_t              wr;
  logic                    tail_valid;
  scan_t                   tail;
  logic [MAJ_W-1:0]        lhs;
  logic [MAJ_W-1:0]        rhs;

  assign cfg.ready  = 1'b1;
  assign busy       = |chain_valid;
  assign item.ready = !busy;
  assign item_xfer  = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= FACTOR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      factor <= cfg.quorum_frac;
    end
  end

  always_comb begin
    wr.en       = item_xfer;
    wr.slot     = item.slot;
    wr.present  = item.present;
    wr.alive    = item.alive;
    wr.id_known = item.id_known;
    wr.uid_high = item.uid_high;
    wr.uid_low  = item.uid_low;
    wr.proposal = item.proposal;
  end

  assign tail_valid = chain_valid[MAX_MEMBERS];
  assign tail       = chain[MAX_MEMBERS];
  assign adv        = !(tail_valid && result.valid && !result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (item_xfer) begin
      start <= 1'b1;
    end else if (adv) begin
      start <= 1'b0;
    end
  end

  assign chain_valid[0] = start;
  assign chain[0]       = '0;

  for (genvar i = 0; i < MAX_MEMBERS; i++) begin : g_cell
    qls_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (CIDX_W'(i)),
      .wr       (wr),
      .adv      (adv),
      .up_valid (chain_valid[i]),
      .up       (chain[i]),
      .dn_valid (chain_valid[i+1]),
      .dn       (chain[i+1])
    );
  end

  assign lhs = MAJ_W'({tail.live_cnt, FRAC_W'(0)});
  assign rhs = MAJ_W'(tail.present_cnt) * MAJ_W'(factor);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv && tail_valid) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_valid) begin
      result.majority     <= (lhs >= rhs);
      result.leader_valid <= tail.found;
      result.leader_slot  <= tail.found ? tail.slot : '0;
    end
  end

`ifndef SYNTHESIS
  a_one_scan: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one scan record in the chain");

  a_launch: assert property (@(posedge clk) disable iff (rst)
    item_xfer |=> start)
    else $error("item transfer did not launch a scan");

  a_tail_hold: assert property (@(posedge clk) disable iff (rst)
    tail_valid && !adv |=> tail_valid && $stable(tail))
    else $error("stalled scan record lost");

  a_no_leader_slot: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.leader_valid |-> result.leader_slot == '0)
    else $error("leader slot set without a leader");
`endif

endmodule

`default_nettype wire

FILE: tb/quorum_leader_select_core_tb.sv
// ----------------------------------------------------------------------------
// quorum_leader_select_core_tb
// Self-checking bench for the quorum leader select core. Member writes are
// driven over the item channel. A scoreboard keeps its own copy of the
// member table and the majority factor, and works out the majority flag and
// the elected leader for every accepted write. Each result transfer is
// checked against the oldest pending verdict. A short directed sequence
// covers ties, equal ids, unknown ids and dead members. Random phases follow
// at factors 0, 256, 511 and random values, with idle gaps on both sides
// in all but the 511 phase, and one long result stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quorum_leader_select_core_tb;
  import qls_pkg::*;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              present;
    logic              alive;
    logic              id_known;
    logic [UID_W-1:0]  uid_high;
    logic [UID_W-1:0]  uid_low;
    logic [PROP_W-1:0] proposal;
  } member_t;

  typedef struct {
    logic              majority;
    logic              leader_valid;
    logic [SLOT_W-1:0] leader_slot;
  } verdict_t;

  class qls_scoreboard;
    logic                tbl_present  [MAX_MEMBERS];
    logic                tbl_alive    [MAX_MEMBERS];
    logic                tbl_id_known [MAX_MEMBERS];
    logic [2*UID_W-1:0]  tbl_uid      [MAX_MEMBERS];
    logic [PROP_W-1:0]   tbl_proposal [MAX_MEMBERS];
    logic [FACTOR_W-1:0] factor;
    verdict_t            verdict_q[$];
    int unsigned         errors;
    int unsigned         writes;
    int unsigned         results;

    function new();
      for (int i = 0; i < MAX_MEMBERS; i++) begin
        tbl_present[i]  = 1'b0;
        tbl_alive[i]    = 1'b0;
        tbl_id_known[i] = 1'b0;
        tbl_uid[i]      = '0;
        tbl_proposal[i] = '0;
      end
      factor  = FACTOR_RESET;
      errors  = 0;
      writes  = 0;
      results = 0;
    endfunction

    function void set_factor(logic [FACTOR_W-1:0] v);
      factor = v;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // table update, then majority count and leader election
    function void record_write(member_t m);
      verdict_t    v;
      int unsigned live_cnt;
      int unsigned present_cnt;
      int          best;
      logic        found;
      live_cnt    = 0;
      present_cnt = 0;
      best        = 0;
      found       = 1'b0;
      if (m.slot < MAX_MEMBERS) begin
        tbl_present[m.slot]  = m.present;
        tbl_alive[m.slot]    = m.alive;
        tbl_id_known[m.slot] = m.id_known;
        tbl_uid[m.slot]      = {m.uid_high, m.uid_low};
        tbl_proposal[m.slot] = m.proposal;
      end
      for (int i = 0; i < MAX_MEMBERS; i++) begin
        if (tbl_present[i])
          present_cnt++;
        if (tbl_present[i] && tbl_alive[i]) begin
          live_cnt++;
          if (tbl_id_known[i]) begin
            if (!found) begin
              found = 1'b1;
              best  = i;
            end else if (tbl_proposal[i] > tbl_proposal[best]) begin
              best = i;
            end else if (tbl_proposal[i] == tbl_proposal[best] &&
                         tbl_uid[i] < tbl_uid[best]) begin
              best = i;
            end
          end
        end
      end
      v.majority     = (live_cnt * 256 >= present_cnt * factor);
      v.leader_valid = found;
      v.leader_slot  = found ? SLOT_W'(best) : '0;
      verdict_q.push_back(v);
      writes++;
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t exp_v;
      results++;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result transfer, actual maj=%0b lv=%0b slot=%0d",
                 $time, got.majority, got.leader_valid, got.leader_slot);
        errors++;
        return;
      end
      exp_v = verdict_q.pop_front();
      if (got.majority !== exp_v.majority) begin
        $display("%0t: majority mismatch, expected %0b, actual %0b",
                 $time, exp_v.majority, got.majority);
        errors++;
      end
      if (got.leader_valid !== exp_v.leader_valid) begin
        $display("%0t: leader_valid mismatch, expected %0b, actual %0b",
                 $time, exp_v.leader_valid, got.leader_valid);
        errors++;
      end
      if (got.leader_slot !== exp_v.leader_slot) begin
        $display("%0t: leader_slot mismatch, expected %0d, actual %0d",
                 $time, exp_v.leader_slot, got.leader_slot);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  qls_item_if   item_ch ();
  qls_cfg_if    cfg_ch ();
  qls_result_if res_ch ();

  quorum_leader_select_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .cfg    (cfg_ch),
    .result (res_ch)
  );

  qls_scoreboard sb;
  int            tx_idle_pct = 18;
  int            rx_idle_pct = 77;
  int            stall_req   = 0;
  int            stall_seen  = 0;
  int            stall_left  = 0;
  int            cfg_writes  = 0;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random backpressure plus long stall on request
  always @(negedge clk) begin
    if (stall_seen != stall_req) begin
      stall_seen = stall_req;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.majority     = res_ch.majority;
      got.leader_valid = res_ch.leader_valid;
      got.leader_slot  = res_ch.leader_slot;
      sb.check_verdict(got);
    end
  end

  function automatic member_t mk(int s, int p, int a, int k,
                                 logic [UID_W-1:0] uh, logic [UID_W-1:0] ul,
                                 logic [PROP_W-1:0] prop);
    member_t m;
    m.slot     = SLOT_W'(s);
    m.present  = (p != 0);
    m.alive    = (a != 0);
    m.id_known = (k != 0);
    m.uid_high = uh;
    m.uid_low  = ul;
    m.proposal = prop;
    return m;
  endfunction

  // small id and proposal pools so that ties are common
  function automatic member_t random_member();
    member_t m;
    m.slot     = SLOT_W'($urandom_range(MAX_MEMBERS - 1));
    m.present  = ($urandom_range(99) < 80);
    m.alive    = ($urandom_range(99) < 75);
    m.id_known = ($urandom_range(99) < 80);
    case ($urandom_range(3))
      0: begin
        m.uid_high = {$urandom, $urandom};
        m.uid_low  = {$urandom, $urandom};
      end
      1: begin
        m.uid_high = UID_W'($urandom_range(1));
        m.uid_low  = {$urandom, $urandom};
      end
      default: begin
        m.uid_high = UID_W'($urandom_range(1));
        m.uid_low  = UID_W'($urandom_range(3));
      end
    endcase
    case ($urandom_range(4))
      0:       m.proposal = $urandom;
      1, 2:    m.proposal = PROP_W'($urandom_range(3));
      default: m.proposal = '1 - PROP_W'($urandom_range(2));
    endcase
    return m;
  endfunction

  task automatic send_member(member_t m);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid    = 1'b1;
    item_ch.slot     = m.slot;
    item_ch.present  = m.present;
    item_ch.alive    = m.alive;
    item_ch.id_known = m.id_known;
    item_ch.uid_high = m.uid_high;
    item_ch.uid_low  = m.uid_low;
    item_ch.proposal = m.proposal;
    do @(posedge clk); while (!item_ch.ready);
    sb.record_write(m);
    @(negedge clk);
  endtask

  task automatic drain();
    item_ch.valid = 1'b0;
    while (sb.pending() != 0)
      @(negedge clk);
  endtask

  task automatic write_factor(logic [FACTOR_W-1:0] v);
    drain();
    cfg_ch.valid       = 1'b1;
    cfg_ch.quorum_frac = v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_factor(v);
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic run_phase(logic [FACTOR_W-1:0] f, int tx_pct, int rx_pct,
                           int n, bit clear_first, bit with_stall);
    write_factor(f);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    // empty quorum at this factor
    if (clear_first)
      for (int s = 0; s < MAX_MEMBERS; s++)
        send_member(mk(s, 0, $urandom_range(1), $urandom_range(1), '0, '0, '0));
    for (int k = 0; k < n; k++) begin
      if (with_stall && k == n / 4)
        stall_req++;
      send_member(random_member());
    end
    drain();
  endtask

  initial begin
    sb                 = new();
    rst                = 1'b1;
    item_ch.valid      = 1'b0;
    item_ch.slot       = '0;
    item_ch.present    = 1'b0;
    item_ch.alive      = 1'b0;
    item_ch.id_known   = 1'b0;
    item_ch.uid_high   = '0;
    item_ch.uid_low    = '0;
    item_ch.proposal   = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.quorum_frac = '0;
    res_ch.ready       = 1'b0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed sequence at the reset factor
    send_member(mk(0, 0, 0, 0, '0, '0, '0));
    send_member(mk(15, 1, 1, 1, '1, '1, '1));
    send_member(mk(0, 1, 1, 1, '0, '0, '1));
    send_member(mk(7, 1, 1, 1, '0, '0, '1));
    send_member(mk(3, 1, 1, 0, '0, '0, '1));
    send_member(mk(0, 1, 1, 1, '0, '0, 32'd5));
    send_member(mk(9, 1, 0, 1, '0, '0, '1));
    send_member(mk(2, 0, 1, 1, '0, '0, '1));
    send_member(mk(7, 0, 1, 1, '0, '0, '1));
    send_member(mk(4, 1, 1, 1, 64'd1, '0, '1));
    send_member(mk(5, 1, 1, 1, '0, '1, '1));
    send_member(mk(6, 1, 1, 1, '0, 64'hFFFF_FFFF_FFFF_FFFE, '1));
    send_member(mk(1, 1, 1, 1, '0, '0, 32'h8000_0000));
    send_member(mk(10, 1, 0, 1, '0, '0, '0));
    send_member(mk(11, 1, 0, 0, '0, '0, '0));
    send_member(mk(12, 1, 0, 1, '1, '0, '1));
    send_member(mk(13, 1, 0, 0, '0, '1, '0));
    send_member(mk(14, 1, 0, 1, '0, '0, '1));
    send_member(mk(8, 1, 1, 0, '1, '1, '1));
    drain();

    run_phase(9'd256, 18, 77, 400, 1'b0, 1'b1);
    run_phase(FACTOR_W'($urandom_range(1, 255)), 18, 77, 400, 1'b0, 1'b0);
    run_phase(9'd0,   77, 18, 400, 1'b0, 1'b0);
    run_phase(FACTOR_W'($urandom_range(511)),    77, 18, 400, 1'b1, 1'b0);
    run_phase(9'd511, 0,  0,  400, 1'b1, 1'b0);

    drain();
    repeat (MAX_MEMBERS + 4) @(negedge clk);
    $display("covered %0d member writes and %0d result transfers", sb.writes, sb.results);
    $display("over %0d majority factor settings incl. 0, 256 and 511", cfg_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout, %0d results still pending", sb.pending());
    $display("Verification failed");
    $finish;
  end

endmodule
